@@ rtl/maxrects_best_short_side_packer_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle packer
// Shared forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef MAXRECTS_BEST_SHORT_SIDE_PACKER_DEFINES_SVH
`define MAXRECTS_BEST_SHORT_SIDE_PACKER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MSPK_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mspk assertion failed");

// Antecedent implies consequent in the next cycle.
`define MSPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mspk assertion failed");

`endif

@@ rtl/mspk_pkg.sv @@
// ----------------------------------------------------------------------------
// mspk_pkg
// Types, codes and sizing constants of the rectangle packer.
// ----------------------------------------------------------------------------
package mspk_pkg;

    localparam int MSPK_MAX_FREE   = 256;
    localparam int MSPK_MAX_SPLIT  = 512;
    localparam int MSPK_WORK_LIMIT = 4000000;

    localparam int COORD_W  = 15;
    localparam int RECT_W   = 4 * COORD_W;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 32;

    localparam logic [COORD_W-1:0] ATLAS_RESET  = 15'd1024;
    localparam logic [COORD_W-1:0] RESV_RESET   = 15'd0;
    localparam logic [CFG_DW-1:0]  BUDGET_RESET = 32'd4000000;

    localparam logic [CFG_IW-1:0] CFG_ATLAS  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_RESV   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BUDGET = 2'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PLACE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_COMPLEX = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SPL_RD,
        S_SPL_EV,
        S_SPL_PC,
        S_PR_I_RD,
        S_PR_I_EV,
        S_PR_J_RD,
        S_PR_J_EV,
        S_CP_RD,
        S_CP_EV
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_rect;

    typedef struct packed {
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
    } t_score;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] req_width;
        logic [COORD_W-1:0] req_height;
    } t_in;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [1:0]         status;
    } t_out;

endpackage

@@ rtl/mspk_ram.sv @@
// ----------------------------------------------------------------------------
// mspk_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module mspk_ram #(
    parameter int DW    = 60,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/mspk_fit.sv @@
// ----------------------------------------------------------------------------
// mspk_fit
// Fit test and best-short-side score compare for one free rectangle.
// ----------------------------------------------------------------------------
module mspk_fit
    import mspk_pkg::*;
(
    input  t_rect              i_f,
    input  logic [COORD_W-1:0] i_w,
    input  logic [COORD_W-1:0] i_h,
    input  t_score             i_best,
    input  logic               i_has_best,
    output logic               o_better,
    output t_score             o_cand
);

    logic               fits;
    logic               less;
    logic [COORD_W-1:0] rw;
    logic [COORD_W-1:0] rh;

    always_comb begin
        fits = (i_w <= i_f.w) && (i_h <= i_f.h);
        rw   = i_f.w - i_w;
        rh   = i_f.h - i_h;
        o_cand.lo = (rw < rh) ? rw : rh;
        o_cand.hi = (rw < rh) ? rh : rw;
        o_cand.y  = i_f.y;
        o_cand.x  = i_f.x;
        o_cand.h  = i_f.h;
        o_cand.w  = i_f.w;
        // strict order; a full tie keeps the earlier index
        if (o_cand.lo != i_best.lo)     less = o_cand.lo < i_best.lo;
        else if (o_cand.hi != i_best.hi) less = o_cand.hi < i_best.hi;
        else if (o_cand.y != i_best.y)   less = o_cand.y < i_best.y;
        else if (o_cand.x != i_best.x)   less = o_cand.x < i_best.x;
        else if (o_cand.h != i_best.h)   less = o_cand.h < i_best.h;
        else                             less = o_cand.w < i_best.w;
        o_better = fits && (!i_has_best || less);
    end

endmodule

@@ rtl/maxrects_best_short_side_packer.sv @@
// ----------------------------------------------------------------------------
// maxrects_best_short_side_packer
// MaxRects atlas packer with best-short-side-fit and containment pruning.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise start while busy is low; that edge takes the
//   transaction. Exactly one result follows on o_res, marked by o_done for
//   one cycle; the receiver cannot stall, so it must take it then.
//   A start command or a place after a sticky failure answers in the next
//   cycle and leaves busy low. A place runs a sequencer over the free table
//   memory and the split table memory, each with one read port:
//     scan   reads each free entry and keeps the best fit
//     split  copies each free entry or cuts an overlapped one into pieces
//     prune  tests the n split pieces pairwise for containment
//     copy   writes the kept pieces back to the free table
//   The pairwise containment loop on the split table read port dominates
//   the cost of a place.
//   Configuration writes on i_cfg_we/i_cfg_idx/i_cfg_data take effect at
//   once; write them only while idle. Writing CFG_BUDGET reloads the budget.
//   Reset empties the free table (count zero), clears the work count and
//   the sticky status, and loads the default budget. No clearing pass.
// ----------------------------------------------------------------------------
`include "maxrects_best_short_side_packer_defines.svh"

module maxrects_best_short_side_packer
    import mspk_pkg::*;
#(
    parameter int MAX_FREE   = MSPK_MAX_FREE,
    parameter int MAX_SPLIT  = MSPK_MAX_SPLIT,
    parameter int WORK_LIMIT = MSPK_WORK_LIMIT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in               i_item,
    output logic              o_done,
    output t_out              o_res,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int FAW = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
    localparam int FCW = $clog2(MAX_FREE + 1);
    localparam int SAW = (MAX_SPLIT > 1) ? $clog2(MAX_SPLIT) : 1;
    localparam int SCW = $clog2(MAX_SPLIT + 1);
    localparam int WCW = $clog2(WORK_LIMIT + 2);

    function automatic logic overlap(t_rect a, t_rect b);
        overlap = ({1'b0, a.x} < {1'b0, b.x} + {1'b0, b.w}) &&
                  ({1'b0, a.x} + {1'b0, a.w} > {1'b0, b.x}) &&
                  ({1'b0, a.y} < {1'b0, b.y} + {1'b0, b.h}) &&
                  ({1'b0, a.y} + {1'b0, a.h} > {1'b0, b.y});
    endfunction

    function automatic logic encloses(t_rect o, t_rect i);
        encloses = (o.x <= i.x) && (o.y <= i.y) &&
                   ({1'b0, o.x} + {1'b0, o.w} >= {1'b0, i.x} + {1'b0, i.w}) &&
                   ({1'b0, o.y} + {1'b0, o.h} >= {1'b0, i.y} + {1'b0, i.h});
    endfunction

    t_state             r_state,  n_state;
    logic [COORD_W-1:0] r_atlas,  n_atlas;
    logic [COORD_W-1:0] r_resv,   n_resv;
    logic [CFG_DW-1:0]  r_budget, n_budget;
    logic [WCW-1:0]     r_work,   n_work;
    t_status            r_sticky, n_sticky;
    logic [FCW-1:0]     r_fcount, n_fcount;
    logic [FCW-1:0]     r_fi,     n_fi;
    logic [FCW-1:0]     r_k,      n_k;
    logic [SCW-1:0]     r_si,     n_si;
    logic [SCW-1:0]     r_sj,     n_sj;
    logic [SCW-1:0]     r_n,      n_n;
    logic [SCW-1:0]     r_rm,     n_rm;
    logic [1:0]         r_pc,     n_pc;
    logic               r_has_best, n_has_best;
    t_score             r_best,   n_best;
    logic [COORD_W-1:0] r_req_w,  n_req_w;
    logic [COORD_W-1:0] r_req_h,  n_req_h;
    t_rect              r_f,      n_f;
    t_rect              r_a,      n_a;
    logic               r_done,   n_done;
    t_out               r_res,    n_res;

    logic               fr_we;
    logic [FAW-1:0]     fr_waddr;
    t_rect              fr_wdata;
    logic [RECT_W-1:0]  fr_rdata;
    t_rect              fr_rd;
    logic               sp_we;
    logic [SAW-1:0]     sp_waddr;
    t_rect              sp_wdata;
    logic [SAW-1:0]     sp_raddr;
    logic [RECT_W-1:0]  sp_rdata;
    t_rect              sp_rd;
    logic               rm_we;
    logic [SAW-1:0]     rm_waddr;
    logic               rm_wdata;
    logic               rm_rd;

    logic               fit_better;
    t_score             fit_cand;
    t_rect              used;
    logic               spend_ok;
    logic               split_full;
    logic [SCW-1:0]     kept;

    logic signed [COORD_W+1:0] fx, fy, fw, fh, ux, uy, uw, uh;
    logic signed [COORD_W+1:0] px, py, pw, ph;
    logic                      pc_valid;

    logic               fin;
    t_status            fin_st;
    logic               fin_pos;

    assign fr_rd = t_rect'(fr_rdata);
    assign sp_rd = t_rect'(sp_rdata);

    mspk_ram #(.DW(RECT_W), .DEPTH(MAX_FREE), .AW(FAW)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_raddr (r_fi[FAW-1:0]),
        .o_rdata (fr_rdata)
    );

    mspk_ram #(.DW(RECT_W), .DEPTH(MAX_SPLIT), .AW(SAW)) u_split_ram (
        .i_clk   (i_clk),
        .i_we    (sp_we),
        .i_waddr (sp_waddr),
        .i_wdata (sp_wdata),
        .i_raddr (sp_raddr),
        .o_rdata (sp_rdata)
    );

    mspk_ram #(.DW(1), .DEPTH(MAX_SPLIT), .AW(SAW)) u_removed_ram (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (rm_waddr),
        .i_wdata (rm_wdata),
        .i_raddr (sp_raddr),
        .o_rdata (rm_rd)
    );

    mspk_fit u_fit (
        .i_f        (fr_rd),
        .i_w        (r_req_w),
        .i_h        (r_req_h),
        .i_best     (r_best),
        .i_has_best (r_has_best),
        .o_better   (fit_better),
        .o_cand     (fit_cand)
    );

    // piece generator for the overlapped free rectangle held in r_f
    always_comb begin
        used = '{x: r_best.x, y: r_best.y, w: r_req_w, h: r_req_h};
        fx = $signed({2'b00, r_f.x});
        fy = $signed({2'b00, r_f.y});
        fw = $signed({2'b00, r_f.w});
        fh = $signed({2'b00, r_f.h});
        ux = $signed({2'b00, used.x});
        uy = $signed({2'b00, used.y});
        uw = $signed({2'b00, used.w});
        uh = $signed({2'b00, used.h});
        case (r_pc)
            2'd0: begin
                px = fx;      py = fy;      pw = ux - fx;           ph = fh;
            end
            2'd1: begin
                px = ux + uw; py = fy;      pw = fx + fw - ux - uw; ph = fh;
            end
            2'd2: begin
                px = fx;      py = fy;      pw = fw;                ph = uy - fy;
            end
            default: begin
                px = fx;      py = uy + uh; pw = fw;                ph = fy + fh - uy - uh;
            end
        endcase
        pc_valid = (pw > 0) && (ph > 0);
    end

    assign spend_ok   = (r_budget != '0) && (r_work < WCW'(WORK_LIMIT));
    assign split_full = 32'(r_n) >= 32'(MAX_SPLIT);
    assign kept       = r_n - r_rm;

    always_comb begin
        n_state    = r_state;
        n_atlas    = r_atlas;
        n_resv     = r_resv;
        n_budget   = r_budget;
        n_work     = r_work;
        n_sticky   = r_sticky;
        n_fcount   = r_fcount;
        n_fi       = r_fi;
        n_k        = r_k;
        n_si       = r_si;
        n_sj       = r_sj;
        n_n        = r_n;
        n_rm       = r_rm;
        n_pc       = r_pc;
        n_has_best = r_has_best;
        n_best     = r_best;
        n_req_w    = r_req_w;
        n_req_h    = r_req_h;
        n_f        = r_f;
        n_a        = r_a;
        n_done     = 1'b0;
        n_res      = r_res;
        fr_we      = 1'b0;
        fr_waddr   = r_k[FAW-1:0];
        fr_wdata   = sp_rd;
        sp_we      = 1'b0;
        sp_waddr   = r_n[SAW-1:0];
        sp_wdata   = fr_rd;
        sp_raddr   = (r_state == S_PR_J_RD) ? r_sj[SAW-1:0] : r_si[SAW-1:0];
        rm_we      = 1'b0;
        rm_waddr   = r_n[SAW-1:0];
        rm_wdata   = 1'b0;
        fin        = 1'b0;
        fin_st     = ST_OK;
        fin_pos    = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATLAS:  n_atlas = i_cfg_data[COORD_W-1:0];
                CFG_RESV:   n_resv  = i_cfg_data[COORD_W-1:0];
                CFG_BUDGET: n_budget = i_cfg_data;
                default:    ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req_w = i_item.req_width;
                    n_req_h = i_item.req_height;
                    if (i_item.cmd == CMD_START) begin
                        fr_waddr = '0;
                        fr_wdata = '{x: r_resv, y: '0, w: r_atlas - r_resv, h: r_atlas};
                        fr_we    = r_atlas > r_resv;
                        n_fcount = (r_atlas > r_resv) ? FCW'(1) : '0;
                        n_work   = '0;
                        fin      = 1'b1;
                    end else if (r_sticky != ST_OK) begin
                        fin    = 1'b1;
                        fin_st = r_sticky;
                    end else begin
                        n_fi       = '0;
                        n_has_best = 1'b0;
                        n_state    = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_fi == r_fcount) begin
                    if (!r_has_best) begin
                        fin    = 1'b1;
                        fin_st = ST_NOFIT;
                    end else begin
                        n_fi    = '0;
                        n_n     = '0;
                        n_state = S_SPL_RD;
                    end
                end else begin
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (r_budget != '0) begin
                    n_work   = r_work + 1'b1;
                    n_budget = r_budget - 1'b1;
                end
                if (!spend_ok) begin
                    fin    = 1'b1;
                    fin_st = ST_COMPLEX;
                end else begin
                    if (fit_better) begin
                        n_best     = fit_cand;
                        n_has_best = 1'b1;
                    end
                    n_fi    = r_fi + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SPL_RD: begin
                if (r_fi == r_fcount) begin
                    n_si    = '0;
                    n_rm    = '0;
                    n_state = S_PR_I_RD;
                end else begin
                    n_state = S_SPL_EV;
                end
            end
            S_SPL_EV: begin
                if (r_budget != '0) begin
                    n_work   = r_work + 1'b1;
                    n_budget = r_budget - 1'b1;
                end
                n_f = fr_rd;
                if (!spend_ok) begin
                    fin    = 1'b1;
                    fin_st = ST_COMPLEX;
                end else if (!overlap(fr_rd, used)) begin
                    if (split_full) begin
                        fin    = 1'b1;
                        fin_st = ST_COMPLEX;
                    end else begin
                        // copy untouched; clear its removed flag alongside
                        sp_we   = 1'b1;
                        rm_we   = 1'b1;
                        n_n     = r_n + 1'b1;
                        n_fi    = r_fi + 1'b1;
                        n_state = S_SPL_RD;
                    end
                end else begin
                    n_pc    = '0;
                    n_state = S_SPL_PC;
                end
            end
            S_SPL_PC: begin
                if (pc_valid && split_full) begin
                    fin    = 1'b1;
                    fin_st = ST_COMPLEX;
                end else begin
                    if (pc_valid) begin
                        sp_we    = 1'b1;
                        rm_we    = 1'b1;
                        sp_wdata = '{x: px[COORD_W-1:0], y: py[COORD_W-1:0],
                                     w: pw[COORD_W-1:0], h: ph[COORD_W-1:0]};
                        n_n      = r_n + 1'b1;
                    end
                    if (r_pc == 2'd3) begin
                        n_fi    = r_fi + 1'b1;
                        n_state = S_SPL_RD;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            S_PR_I_RD: begin
                if (r_si == r_n) begin
                    if (32'(kept) > 32'(MAX_FREE)) begin
                        fin    = 1'b1;
                        fin_st = ST_COMPLEX;
                    end else begin
                        n_si    = '0;
                        n_k     = '0;
                        n_state = S_CP_RD;
                    end
                end else begin
                    n_state = S_PR_I_EV;
                end
            end
            S_PR_I_EV: begin
                n_a = sp_rd;
                if (rm_rd) begin
                    n_si    = r_si + 1'b1;
                    n_state = S_PR_I_RD;
                end else begin
                    n_sj    = '0;
                    n_state = S_PR_J_RD;
                end
            end
            S_PR_J_RD: begin
                if (r_sj == r_n) begin
                    n_si    = r_si + 1'b1;
                    n_state = S_PR_I_RD;
                end else if (r_sj == r_si) begin
                    n_sj = r_sj + 1'b1;
                end else begin
                    n_state = S_PR_J_EV;
                end
            end
            S_PR_J_EV: begin
                if (rm_rd) begin
                    n_sj    = r_sj + 1'b1;
                    n_state = S_PR_J_RD;
                end else begin
                    if (r_budget != '0) begin
                        n_work   = r_work + 1'b1;
                        n_budget = r_budget - 1'b1;
                    end
                    if (!spend_ok) begin
                        fin    = 1'b1;
                        fin_st = ST_COMPLEX;
                    end else if (encloses(sp_rd, r_a)) begin
                        rm_we    = 1'b1;
                        rm_waddr = r_si[SAW-1:0];
                        rm_wdata = 1'b1;
                        n_rm     = r_rm + 1'b1;
                        n_si     = r_si + 1'b1;
                        n_state  = S_PR_I_RD;
                    end else begin
                        n_sj    = r_sj + 1'b1;
                        n_state = S_PR_J_RD;
                    end
                end
            end
            S_CP_RD: begin
                if (r_si == r_n) begin
                    n_fcount = r_k;
                    fin      = 1'b1;
                    fin_pos  = 1'b1;
                end else begin
                    n_state = S_CP_EV;
                end
            end
            S_CP_EV: begin
                if (!rm_rd) begin
                    fr_we = 1'b1;
                    n_k   = r_k + 1'b1;
                end
                n_si    = r_si + 1'b1;
                n_state = S_CP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_done       = 1'b1;
            n_sticky     = fin_st;
            n_res.status = fin_st;
            n_res.pos_x  = fin_pos ? r_best.x : '0;
            n_res.pos_y  = fin_pos ? r_best.y : '0;
            n_state      = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_atlas    <= ATLAS_RESET;
            r_resv     <= RESV_RESET;
            r_budget   <= BUDGET_RESET;
            r_work     <= '0;
            r_sticky   <= ST_OK;
            r_fcount   <= '0;
            r_fi       <= '0;
            r_k        <= '0;
            r_si       <= '0;
            r_sj       <= '0;
            r_n        <= '0;
            r_rm       <= '0;
            r_pc       <= '0;
            r_has_best <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_atlas    <= n_atlas;
            r_resv     <= n_resv;
            r_budget   <= n_budget;
            r_work     <= n_work;
            r_sticky   <= n_sticky;
            r_fcount   <= n_fcount;
            r_fi       <= n_fi;
            r_k        <= n_k;
            r_si       <= n_si;
            r_sj       <= n_sj;
            r_n        <= n_n;
            r_rm       <= n_rm;
            r_pc       <= n_pc;
            r_has_best <= n_has_best;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best  <= n_best;
        r_req_w <= n_req_w;
        r_req_h <= n_req_h;
        r_f     <= n_f;
        r_a     <= n_a;
        r_res   <= n_res;
    end

    assign busy   = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_res  = r_res;

    `MSPK_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE)
    `MSPK_ASSERT_NEXT(a_start_answers, i_clk, i_rst_n,
        start && !busy && (i_item.cmd == CMD_START),
        r_done && (r_res.status == ST_OK) && (r_sticky == ST_OK))
    `MSPK_ASSERT_SAME(a_fail_no_pos, i_clk, i_rst_n,
        r_done && (r_res.status != ST_OK), (r_res.pos_x == '0) && (r_res.pos_y == '0))
    `MSPK_ASSERT_SAME(a_free_bound, i_clk, i_rst_n, 1'b1,
        32'(r_fcount) <= 32'(MAX_FREE))

endmodule

@@ dv/mspk_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspk_checker
// Watches the command, result and register write ports of the rectangle
// packer. It keeps its own free-rectangle table and predicts each result,
// then compares every result field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module mspk_checker
    import mspk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  t_in               i_item,
    input  logic              o_done,
    input  t_out              o_res,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_outstanding
);

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } t_box;

    int unsigned atlas_sz;
    int unsigned resv_w;
    int unsigned budget_left;
    int unsigned work_cnt;
    t_status     sticky;
    t_box        free_tab [MSPK_MAX_FREE];
    int          free_cnt;
    t_box        piece_tab [MSPK_MAX_SPLIT];
    bit          piece_gone [MSPK_MAX_SPLIT];
    t_out        exp_results [$];

    function automatic bit spend_unit();
        if (budget_left == 0)
            return 1'b0;
        work_cnt++;
        budget_left--;
        return work_cnt <= MSPK_WORK_LIMIT;
    endfunction

    function automatic bit overlaps(t_box a, t_box b);
        return a.x < b.x + b.w && a.x + a.w > b.x && a.y < b.y + b.h && a.y + a.h > b.y;
    endfunction

    function automatic bit encloses(t_box o, t_box i);
        return o.x <= i.x && o.y <= i.y && o.x + o.w >= i.x + i.w &&
               o.y + o.h >= i.y + i.h;
    endfunction

    function automatic bit add_piece(ref int n, input int x, int y, int w, int h);
        if (w <= 0 || h <= 0)
            return 1'b1;
        if (n >= MSPK_MAX_SPLIT)
            return 1'b0;
        piece_tab[n] = '{x, y, w, h};
        n++;
        return 1'b1;
    endfunction

    // Split every free rectangle hit by the placed one, then prune enclosed pieces.
    function automatic t_status split_free(t_box u);
        int   n;
        int   kept;
        bit   ok;
        t_box f;
        n = 0;
        for (int i = 0; i < free_cnt; i++) begin
            f = free_tab[i];
            if (!spend_unit())
                return ST_COMPLEX;
            if (!overlaps(f, u)) begin
                if (n >= MSPK_MAX_SPLIT)
                    return ST_COMPLEX;
                piece_tab[n] = f;
                n++;
            end else begin
                ok = add_piece(n, f.x, f.y, u.x - f.x, f.h);
                ok = ok && add_piece(n, u.x + u.w, f.y, f.x + f.w - (u.x + u.w), f.h);
                ok = ok && add_piece(n, f.x, f.y, f.w, u.y - f.y);
                ok = ok && add_piece(n, f.x, u.y + u.h, f.w, f.y + f.h - (u.y + u.h));
                if (!ok)
                    return ST_COMPLEX;
            end
        end
        for (int i = 0; i < MSPK_MAX_SPLIT; i++)
            piece_gone[i] = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (piece_gone[i])
                continue;
            for (int j = 0; j < n; j++) begin
                if (i == j || piece_gone[j])
                    continue;
                if (!spend_unit())
                    return ST_COMPLEX;
                if (encloses(piece_tab[j], piece_tab[i])) begin
                    piece_gone[i] = 1'b1;
                    break;
                end
            end
        end
        kept = 0;
        for (int i = 0; i < n; i++)
            if (!piece_gone[i])
                kept++;
        if (kept > MSPK_MAX_FREE)
            return ST_COMPLEX;
        kept = 0;
        for (int i = 0; i < n; i++)
            if (!piece_gone[i]) begin
                free_tab[kept] = piece_tab[i];
                kept++;
            end
        free_cnt = kept;
        return ST_OK;
    endfunction

    function automatic t_out predict_packing(t_in it);
        t_out r;
        int   w;
        int   h;
        int   best_idx;
        int   best [7];
        int   s [7];
        int   rw;
        int   rh;
        bit   better;
        t_box f;
        t_box used;
        t_status st;
        r = '0;
        r.status = ST_OK;
        if (it.cmd == CMD_START) begin
            free_cnt = 0;
            if (int'(atlas_sz) - int'(resv_w) > 0 && atlas_sz > 0) begin
                free_tab[0] = '{int'(resv_w), 0, int'(atlas_sz) - int'(resv_w), int'(atlas_sz)};
                free_cnt = 1;
            end
            work_cnt = 0;
            sticky   = ST_OK;
            return r;
        end
        if (sticky != ST_OK) begin
            r.status = sticky;
            return r;
        end
        w = int'(it.req_width);
        h = int'(it.req_height);
        best_idx = -1;
        for (int i = 0; i < free_cnt; i++) begin
            f = free_tab[i];
            if (!spend_unit()) begin
                sticky   = ST_COMPLEX;
                r.status = ST_COMPLEX;
                return r;
            end
            if (w > f.w || h > f.h)
                continue;
            rw = f.w - w;
            rh = f.h - h;
            s[0] = rw < rh ? rw : rh;
            s[1] = rw < rh ? rh : rw;
            s[2] = f.y;
            s[3] = f.x;
            s[4] = f.h;
            s[5] = f.w;
            s[6] = i;
            better = best_idx < 0;
            for (int k = 0; k < 7 && !better; k++)
                if (s[k] != best[k]) begin
                    better = s[k] < best[k];
                    break;
                end
            if (better) begin
                best     = s;
                best_idx = i;
            end
        end
        if (best_idx < 0) begin
            sticky   = ST_NOFIT;
            r.status = ST_NOFIT;
            return r;
        end
        used   = free_tab[best_idx];
        used.w = w;
        used.h = h;
        st = split_free(used);
        if (st != ST_OK) begin
            sticky   = st;
            r.status = st;
            return r;
        end
        r.pos_x = used.x[COORD_W-1:0];
        r.pos_y = used.y[COORD_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            atlas_sz    = ATLAS_RESET;
            resv_w      = RESV_RESET;
            budget_left = BUDGET_RESET;
            work_cnt    = 0;
            free_cnt    = 0;
            sticky      = ST_OK;
            exp_results.delete();
            o_fail_count <= 0;
        end else begin
            if (o_done) begin
                if (exp_results.size() == 0) begin
                    $display("%0t: unexpected result: actual %p", $time, o_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = exp_results.pop_front();
                    if (o_res.pos_x !== exp_r.pos_x || o_res.pos_y !== exp_r.pos_y ||
                        o_res.status !== exp_r.status) begin
                        $display("%0t: mismatch: expected %p actual %p", $time, exp_r, o_res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // queue the expectation behind any still waiting
            if (start && !busy)
                exp_results = {exp_results, predict_packing(i_item)};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ATLAS:  atlas_sz = i_cfg_data[COORD_W-1:0];
                    CFG_RESV:   resv_w   = i_cfg_data[COORD_W-1:0];
                    CFG_BUDGET: budget_left = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding <= exp_results.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives start and place commands and register writes into the rectangle
// packer in random bursts; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import mspk_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_in               i_item = '0;
    logic              o_done;
    t_out              o_res;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    int                fail_count;
    int                outstanding;
    int                cycle_cnt = 0;
    int                burst_left = 0;
    int unsigned       cur_atlas = 1024;

    maxrects_best_short_side_packer dut (.*);

    mspk_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_done, .o_res,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 8000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Hold start until the transaction is taken; drop it only at a gap.
    task automatic send(input logic cmd, input int w, input int h);
        start  <= 1'b1;
        i_item <= '{cmd, w[COORD_W-1:0], h[COORD_W-1:0]};
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start  <= 1'b0;
            i_item <= '{1'b1, 15'($urandom), 15'($urandom)};
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
        end
    endtask

    task automatic drain();
        if (start) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        while (outstanding != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_ATLAS)
            cur_atlas = data[COORD_W-1:0];
    endtask

    task automatic random_places(input int count);
        int span;
        span = (cur_atlas < 12) ? 4 : cur_atlas / 3;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0:       send(CMD_START, $urandom_range(0, 32767), $urandom_range(0, 32767));
                1:       send(CMD_PLACE, $urandom_range(0, 16384), $urandom_range(0, 16384));
                2:       send(CMD_PLACE, 0, $urandom_range(0, span));
                default: send(CMD_PLACE, $urandom_range(1, span), $urandom_range(1, span));
            endcase
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: place before any start, then basic and edge sizes
        send(CMD_PLACE, 10, 10);
        send(CMD_PLACE, 1, 1);
        send(CMD_START, 16383, 16383);
        send(CMD_PLACE, 0, 0);
        send(CMD_PLACE, 100, 200);
        send(CMD_PLACE, 300, 50);
        send(CMD_PLACE, 1025, 1);
        send(CMD_PLACE, 5, 5);
        send(CMD_START, 0, 0);
        send(CMD_PLACE, 1024, 1024);
        send(CMD_PLACE, 1, 1);
        write_reg(CFG_ATLAS, 16384);
        write_reg(CFG_RESV, 16384);
        send(CMD_START, 0, 0);
        send(CMD_PLACE, 0, 0);
        write_reg(CFG_RESV, 100);
        write_reg(2'd3, 32'hFFFF_FFFF);
        send(CMD_START, 0, 0);
        send(CMD_PLACE, 16284, 16384);
        send(CMD_PLACE, 16383, 16383);
        write_reg(CFG_ATLAS, 0);
        write_reg(CFG_RESV, 0);
        send(CMD_START, 0, 0);
        send(CMD_PLACE, 0, 0);
        write_reg(CFG_ATLAS, 64);
        write_reg(CFG_BUDGET, 0);
        send(CMD_START, 0, 0);
        send(CMD_PLACE, 4, 4);
        send(CMD_PLACE, 4, 4);
        write_reg(CFG_BUDGET, 7);
        send(CMD_START, 0, 0);
        send(CMD_PLACE, 8, 8);
        send(CMD_PLACE, 8, 8);
        send(CMD_PLACE, 8, 8);

        // random phases with varied register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_reg(CFG_ATLAS, 16384);
                1: write_reg(CFG_ATLAS, 32'($urandom_range(8, 40)));
                default: write_reg(CFG_ATLAS, 32'($urandom_range(64, 1024)));
            endcase
            write_reg(CFG_RESV, (ph == 3) ? 32'(cur_atlas + 5) :
                                32'($urandom_range(0, cur_atlas / 2)));
            write_reg(CFG_BUDGET, (ph == 4) ? 32'($urandom_range(200, 2000)) :
                                  (ph == 5) ? 32'hFFFF_FFFF : BUDGET_RESET);
            for (int s = 0; s < 6; s++) begin
                send(CMD_START, $urandom_range(0, 32767), $urandom_range(0, 32767));
                random_places($urandom_range(8, 14));
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
